>>> rtl/core/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg: shared definitions for the indexed list engine
// Command and status codes, fixed field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic by_value;  // match on stored value against the key
    logic by_index;  // match on cell position against the target
    logic write_en;  // store the key in the cell at the target
    logic shift_en;  // cells at or above the target take their upper neighbour
  } cell_ctl_t;

endpackage

>>> rtl/core/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell: one slot of the list chain
// Holds one entry, takes part in the pipelined search bus and shifts down.
// ----------------------------------------------------------------------------
module ile_cell #(
  parameter int EW  = 32,
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ile_pkg::cell_ctl_t ctl,
  input  logic              live,
  input  logic [EW-1:0]     key,
  input  logic [IW-1:0]     target,
  input  logic [EW-1:0]     nbr_slot,
  output logic [EW-1:0]     slot_q,
  input  logic              bus_hit_i,
  input  logic [IW-1:0]     bus_pos_i,
  input  logic [EW-1:0]     bus_val_i,
  output logic              bus_hit_o,
  output logic [IW-1:0]     bus_pos_o,
  output logic [EW-1:0]     bus_val_o
);

  localparam logic [IW-1:0] MY_POS = IW'(IDX);

  logic [EW-1:0] slot_r;
  logic          bus_hit_r;
  logic [IW-1:0] bus_pos_r;
  logic [EW-1:0] bus_val_r;
  logic          at_target;
  logic          sel;

  assign at_target = (target == MY_POS);
  assign sel = live && ((ctl.by_value && (slot_r == key)) ||
                        (ctl.by_index && at_target));

  always_ff @(posedge clk) begin
    if (ctl.write_en && at_target) begin
      slot_r <= key;
    end else if (ctl.shift_en && (MY_POS >= target)) begin
      slot_r <= nbr_slot;
    end
  end

  // The first hit along the chain wins; later cells pass it on untouched.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_hit_r <= 1'b0;
    end else begin
      bus_hit_r <= bus_hit_i || sel;
    end
  end

  always_ff @(posedge clk) begin
    if (bus_hit_i || !sel) begin
      bus_pos_r <= bus_pos_i;
      bus_val_r <= bus_val_i;
    end else begin
      bus_pos_r <= MY_POS;
      bus_val_r <= slot_r;
    end
  end

  assign slot_q    = slot_r;
  assign bus_hit_o = bus_hit_r;
  assign bus_pos_o = bus_pos_r;
  assign bus_val_o = bus_val_r;

endmodule

>>> rtl/core/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered list of handles in a chain of slot cells
// Sequencing: append, set and unused codes go from idle straight to the
// execute state; get, pop, find and remove first pass the scan state, which
// waits for the registered search bus that runs one cell per cycle along the chain.
// Flow: one command at a time; a new word is taken only while idle.
// Reset: clears the entry count and control; slot contents stay undefined.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ile_pkg::CMD_W-1:0]   in_cmd,
  input  logic [ile_pkg::IDX_W-1:0]   in_slot_index,
  input  logic [ile_pkg::VAL_W-1:0]   in_item_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ile_pkg::VAL_W-1:0]   out_read_value,
  output logic [ile_pkg::IDX_W-1:0]   out_found_position,
  output logic [ile_pkg::STAT_W-1:0]  out_status,
  output logic [ile_pkg::CNT_W-1:0]   out_used_count
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int EW   = ELEM_WIDTH;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [IW-1:0]                  scan_cnt_r, scan_cnt_nxt;
  logic [CNTW-1:0]                count_r, count_nxt;
  logic [ile_pkg::CMD_W-1:0]      cmd_r;
  logic [ile_pkg::IDX_W-1:0]      idx_r;
  logic [EW-1:0]                  key_r;

  logic                           out_valid_r;
  logic [ile_pkg::VAL_W-1:0]      out_val_r, out_val_nxt;
  logic [ile_pkg::IDX_W-1:0]      out_pos_r, out_pos_nxt;
  logic [ile_pkg::STAT_W-1:0]     out_stat_r, out_stat_nxt;
  logic [ile_pkg::CNT_W-1:0]      out_cnt_r;

  logic                           accept;
  logic                           fire;
  logic                           scan_cmd;
  logic [31:0]                    idx_ext;
  logic                           idx_lt_cnt;
  logic                           idx_lt_depth;
  logic                           full;
  logic                           do_write, do_shift;
  logic [IW-1:0]                  target;
  ile_pkg::cell_ctl_t             ctl;

  // Chain wiring: slot values and the pipelined search bus, one tap per cell.
  logic [EW-1:0]                  slot_q  [DEPTH];
  logic                           bus_hit [DEPTH];
  logic [IW-1:0]                  bus_pos [DEPTH];
  logic [EW-1:0]                  bus_val [DEPTH];
  logic                           end_hit;
  logic [IW-1:0]                  end_pos;
  logic [EW-1:0]                  end_val;

  assign end_hit = bus_hit[DEPTH-1];
  assign end_pos = bus_pos[DEPTH-1];
  assign end_val = bus_val[DEPTH-1];

  // A new word is taken only while the sequencer is idle; the output register
  // lets a finished result wait without holding up the next command.
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    case (in_cmd) inside
      ile_pkg::CMD_GET, ile_pkg::CMD_POP,
      ile_pkg::CMD_FIND, ile_pkg::CMD_REMOVE: scan_cmd = 1'b1;
      default:                                scan_cmd = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = scan_cmd ? S_SCAN : S_EXEC;
          scan_cnt_nxt = '0;
        end
      end
      S_SCAN: begin
        // The scan runs until the bus has passed the last cell of the chain.
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == IW'(DEPTH - 1)) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      idx_r <= in_slot_index;
      key_r <= EW'(in_item_value);
    end
  end

  // Range checks are made at a common width so any DEPTH works.
  assign idx_ext      = 32'(idx_r);
  assign idx_lt_cnt   = (idx_ext < 32'(count_r));
  assign idx_lt_depth = (idx_ext < 32'(DEPTH));
  assign full         = (count_r == CNTW'(DEPTH));

  // Append writes at the count, remove shifts from the matched position and
  // the other commands use the slot index of the word.
  always_comb begin
    if (cmd_r == ile_pkg::CMD_APPEND) begin
      target = count_r[IW-1:0];
    end else if (cmd_r == ile_pkg::CMD_REMOVE) begin
      target = end_pos;
    end else begin
      target = idx_ext[IW-1:0];
    end
  end

  always_comb begin
    out_val_nxt  = '0;
    out_pos_nxt  = '0;
    out_stat_nxt = ile_pkg::ST_OK;
    count_nxt    = count_r;
    do_write     = 1'b0;
    do_shift     = 1'b0;
    case (cmd_r)
      ile_pkg::CMD_APPEND: begin
        if (full) begin
          out_stat_nxt = ile_pkg::ST_FULL;
        end else begin
          do_write  = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      ile_pkg::CMD_GET: begin
        if (idx_lt_cnt) begin
          out_val_nxt = ile_pkg::VAL_W'(end_val);
        end else begin
          out_stat_nxt = ile_pkg::ST_RANGE;
        end
      end
      ile_pkg::CMD_SET: begin
        if (idx_lt_depth) begin
          do_write = 1'b1;
        end else begin
          out_stat_nxt = ile_pkg::ST_RANGE;
        end
      end
      ile_pkg::CMD_POP: begin
        if (idx_lt_cnt) begin
          out_val_nxt = ile_pkg::VAL_W'(end_val);
          do_shift    = 1'b1;
          count_nxt   = count_r - 1'b1;
        end else begin
          out_stat_nxt = ile_pkg::ST_RANGE;
        end
      end
      ile_pkg::CMD_FIND: begin
        if (end_hit) begin
          out_pos_nxt = ile_pkg::IDX_W'(end_pos);
        end else begin
          out_stat_nxt = ile_pkg::ST_NOT_FOUND;
        end
      end
      ile_pkg::CMD_REMOVE: begin
        if (end_hit) begin
          out_val_nxt = ile_pkg::VAL_W'(end_val);
          out_pos_nxt = ile_pkg::IDX_W'(end_pos);
          do_shift    = 1'b1;
          count_nxt   = count_r - 1'b1;
        end else begin
          out_stat_nxt = ile_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        out_stat_nxt = ile_pkg::ST_OK;
      end
    endcase
  end

  // Matching is enabled throughout; stores and shifts happen only on the
  // cycle at which the result word is loaded.
  always_comb begin
    ctl.by_value = (cmd_r == ile_pkg::CMD_FIND) || (cmd_r == ile_pkg::CMD_REMOVE);
    ctl.by_index = (cmd_r == ile_pkg::CMD_GET) || (cmd_r == ile_pkg::CMD_POP);
    ctl.write_en = fire && do_write;
    ctl.shift_en = fire && do_shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_val_r  <= out_val_nxt;
      out_pos_r  <= out_pos_nxt;
      out_stat_r <= out_stat_nxt;
      out_cnt_r  <= ile_pkg::CNT_W'(count_nxt);
    end
  end

  // The chain itself: cell zero sees an empty bus, the top cell shifts in
  // zero, which only ever lands in a slot beyond the count.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic          live;
    logic          hit_in;
    logic [IW-1:0] pos_in;
    logic [EW-1:0] val_in;
    logic [EW-1:0] nbr;

    assign live = (CNTW'(k) < count_r);

    if (k == 0) begin : g_first
      assign hit_in = 1'b0;
      assign pos_in = '0;
      assign val_in = '0;
    end else begin : g_rest
      assign hit_in = bus_hit[k-1];
      assign pos_in = bus_pos[k-1];
      assign val_in = bus_val[k-1];
    end

    if (k == DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = slot_q[k+1];
    end

    ile_cell #(
      .EW  (EW),
      .IW  (IW),
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .live      (live),
      .key       (key_r),
      .target    (target),
      .nbr_slot  (nbr),
      .slot_q    (slot_q[k]),
      .bus_hit_i (hit_in),
      .bus_pos_i (pos_in),
      .bus_val_i (val_in),
      .bus_hit_o (bus_hit[k]),
      .bus_pos_o (bus_pos[k]),
      .bus_val_o (bus_val[k])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_val_r;
  assign out_found_position = out_pos_r;
  assign out_status         = out_stat_r;
  assign out_used_count     = out_cnt_r;

endmodule

>>> dv/indexed_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_tb: self-checking bench for the indexed list engine
// A directed table walks the empty, partly filled and special cases, then
// random phases of command words fill, search and drain the list while both
// channels idle in bursts. Every result word is checked against a hand-written expectation or a predictor.
// ----------------------------------------------------------------------------
module indexed_list_engine_tb;
  import ile_pkg::*;

  localparam int DEPTH         = 64;
  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int POOL_SIZE     = 12;
  localparam int PHASES        = 10;
  localparam int PHASE_WORDS   = 188;
  localparam int LONG_HOLD_AT  = 6000;
  localparam int LONG_HOLD_LEN = 400;

  // The two command codes that the block must treat as no-operations.
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [VAL_W-1:0]  read_value;
    logic [IDX_W-1:0]  found_position;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  used_count;
  } list_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    bit               typed;
    list_result_t     want;
  } stim_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_SEARCH, MIX_BALANCED} mix_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   in_cmd;
  logic [IDX_W-1:0]   in_slot_index;
  logic [VAL_W-1:0]   in_item_value;
  logic               out_valid;
  logic               out_ready;
  logic [VAL_W-1:0]   out_read_value;
  logic [IDX_W-1:0]   out_found_position;
  logic [STAT_W-1:0]  out_status;
  logic [CNT_W-1:0]   out_used_count;

  // Travels alongside the payload so that the acceptance monitor knows
  // whether the word carries a hand-written expectation.
  bit                 word_typed;
  list_result_t       word_want;

  // Shadow of the list as the predictor sees it.
  logic [VAL_W-1:0]   list_mem [DEPTH];
  int                 list_len;

  list_result_t       pending_results [$];
  stim_row_t          directed_rows [$];
  logic [VAL_W-1:0]   value_pool [POOL_SIZE];
  int                 mismatch_count;
  bit                 calm;
  int                 rx_cycle;
  int                 rx_hold;

  indexed_list_engine #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (VAL_W)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_slot_index      (in_slot_index),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_status         (out_status),
    .out_used_count     (out_used_count)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Takes an entry out of the list and closes the gap behind it.
  function automatic logic [VAL_W-1:0] take_slot(int pos);
    logic [VAL_W-1:0] v;
    v = list_mem[pos];
    for (int k = pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
    list_len--;
    return v;
  endfunction

  // Applies one command word to the shadow list and returns its result word.
  function automatic list_result_t list_step(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                             logic [VAL_W-1:0] val);
    list_result_t r;
    int           pos;
    bit           hit;
    r   = '0;
    pos = 0;
    hit = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      CMD_GET: begin
        if (int'(idx) >= list_len) r.status = ST_RANGE;
        else r.read_value = list_mem[idx];
      end
      CMD_SET: begin
        // Any slot below the depth may be written, used or not.
        if (int'(idx) >= DEPTH) r.status = ST_RANGE;
        else list_mem[idx] = val;
      end
      CMD_POP: begin
        if (int'(idx) >= list_len) r.status = ST_RANGE;
        else r.read_value = take_slot(int'(idx));
      end
      CMD_FIND, CMD_REMOVE: begin
        // Only the first used position that matches counts.
        for (int k = 0; k < list_len && !hit; k++) begin
          if (list_mem[k] == val) begin
            hit = 1'b1;
            pos = k;
          end
        end
        if (!hit) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found_position = pos[IDX_W-1:0];
          if (cmd == CMD_REMOVE) r.read_value = take_slot(pos);
        end
      end
      default: ;
    endcase
    r.used_count = list_len[CNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Acceptance monitor and result checker
  // --------------------------------------------------------------------------

  // The predictor runs on every accepted word so that its state follows the
  // block, even where the table supplies the expectation by hand.
  always @(posedge clk) begin : accept_mon
    list_result_t predicted;
    if (rst_n && in_valid && in_ready) begin
      predicted = list_step(in_cmd, in_slot_index, in_item_value);
      if (word_typed) pending_results.push_back(word_want);
      else pending_results.push_back(predicted);
    end
  end

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_chk
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing pending, got read_value %0h status %0h",
                 $time, out_read_value, out_status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, out_read_value);
        check_field("found_position", VAL_W'(want.found_position), VAL_W'(out_found_position));
        check_field("status", VAL_W'(want.status), VAL_W'(out_status));
        check_field("used_count", VAL_W'(want.used_count), VAL_W'(out_used_count));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off while the sender is
  // still busy, so that the block backs up and lowers in_ready.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycle = 0;
      rx_hold  = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle == LONG_HOLD_AT) rx_hold = LONG_HOLD_LEN;
      else if (rx_hold == 0 && !calm && $urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 9);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offers one word, possibly after an idle burst, and returns at the edge
  // that accepts it. in_valid is left high so that a following word can be
  // presented at once.
  task automatic send_word(logic [CMD_W-1:0] c, logic [IDX_W-1:0] i, logic [VAL_W-1:0] v,
                           bit typed, list_result_t want);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_slot_index <= i;
    in_item_value <= v;
    word_typed    <= typed;
    word_want     <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every result word has been checked.
  task automatic wait_list_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(logic [CMD_W-1:0] c, logic [IDX_W-1:0] i, logic [VAL_W-1:0] v,
                         bit typed, logic [VAL_W-1:0] rv, logic [IDX_W-1:0] pos,
                         logic [STAT_W-1:0] st, logic [CNT_W-1:0] cnt);
    stim_row_t row;
    row.cmd   = c;
    row.idx   = i;
    row.val   = v;
    row.typed = typed;
    row.want  = '{read_value: rv, found_position: pos, status: st, used_count: cnt};
    directed_rows.push_back(row);
  endtask

  // Picks a command according to the mix of the phase; a few per cent of
  // the words use the spare codes.
  function automatic logic [CMD_W-1:0] pick_cmd(mix_t m);
    int               w [6];
    logic [CMD_W-1:0] code_of [6];
    int               r;
    int               acc;
    code_of = '{CMD_APPEND, CMD_GET, CMD_SET, CMD_POP, CMD_FIND, CMD_REMOVE};
    case (m)
      MIX_FILL:   w = '{70, 8, 6, 4, 4, 4};
      MIX_DRAIN:  w = '{20, 10, 5, 30, 10, 21};
      MIX_SEARCH: w = '{30, 10, 10, 5, 25, 16};
      default:    w = '{35, 15, 10, 14, 12, 10};
    endcase
    r = $urandom_range(0, 99);
    if (r < 4) return ($urandom_range(0, 1) != 0) ? CMD_SPARE7 : CMD_SPARE6;
    acc = 4;
    for (int k = 0; k < 6; k++) begin
      acc += w[k];
      if (r < acc) return code_of[k];
    end
    return CMD_APPEND;
  endfunction

  // Indices lean towards the used part of the list, but the whole field is
  // covered.
  function automatic logic [IDX_W-1:0] pick_index();
    int hi;
    if ($urandom_range(0, 9) < 4) return IDX_W'($urandom_range(0, DEPTH - 1));
    hi = (list_len > DEPTH - 1) ? DEPTH - 1 : list_len;
    return IDX_W'($urandom_range(0, hi));
  endfunction

  // Values come half from a small pool, so that searches hit and duplicates
  // appear, and half fully at random.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) != 0) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  initial begin : main_seq
    stim_row_t    row;
    mix_t         mix;
    list_result_t none;
    none           = '0;
    mismatch_count = 0;
    calm           = 1'b0;
    list_len       = 0;
    for (int k = 0; k < DEPTH; k++) list_mem[k] = '0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_APPEND;
    in_slot_index <= '0;
    in_item_value <= '0;
    word_typed    <= 1'b0;
    word_want     <= '0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) value_pool[k] = $urandom();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Rows marked 1 carry the result by hand; the others are
    // left to the predictor.
    // The empty list: reads and pops are out of range, searches miss.
    add_row(CMD_GET,    6'd0,  32'h0,         1, 32'h0, 6'd0, ST_RANGE,     7'd0);
    add_row(CMD_POP,    6'd0,  32'h0,         1, 32'h0, 6'd0, ST_RANGE,     7'd0);
    add_row(CMD_FIND,   6'd0,  32'h0,         1, 32'h0, 6'd0, ST_NOT_FOUND, 7'd0);
    add_row(CMD_REMOVE, 6'd63, 32'hFFFF_FFFF, 1, 32'h0, 6'd0, ST_NOT_FOUND, 7'd0);
    // A set beyond the count is still in range and leaves the count alone.
    add_row(CMD_SET,    6'd63, 32'hA5A5_A5A5, 1, 32'h0, 6'd0, ST_OK,        7'd0);
    add_row(CMD_APPEND, 6'd0,  32'hFFFF_FFFF, 1, 32'h0, 6'd0, ST_OK,        7'd1);
    add_row(CMD_APPEND, 6'd63, 32'h0,         1, 32'h0, 6'd0, ST_OK,        7'd2);
    add_row(CMD_APPEND, 6'd5,  32'h1234_5678, 1, 32'h0, 6'd0, ST_OK,        7'd3);
    add_row(CMD_GET,    6'd0,  32'h0,         1, 32'hFFFF_FFFF, 6'd0, ST_OK, 7'd3);
    add_row(CMD_GET,    6'd2,  32'hFFFF_FFFF, 1, 32'h1234_5678, 6'd0, ST_OK, 7'd3);
    // Reads at the count and at the top slot miss.
    add_row(CMD_GET,    6'd3,  32'h0,         1, 32'h0, 6'd0, ST_RANGE,     7'd3);
    add_row(CMD_GET,    6'd63, 32'h0,         1, 32'h0, 6'd0, ST_RANGE,     7'd3);
    add_row(CMD_FIND,   6'd0,  32'h0,         1, 32'h0, 6'd1, ST_OK,        7'd3);
    add_row(CMD_FIND,   6'd63, 32'h1234_5678, 1, 32'h0, 6'd2, ST_OK,        7'd3);
    add_row(CMD_SET,    6'd1,  32'h5A5A_5A5A, 1, 32'h0, 6'd0, ST_OK,        7'd3);
    // The spare codes change nothing and report success.
    add_row(CMD_SPARE6, 6'd63, 32'hFFFF_FFFF, 1, 32'h0, 6'd0, ST_OK,        7'd3);
    add_row(CMD_SPARE7, 6'd0,  32'h0,         1, 32'h0, 6'd0, ST_OK,        7'd3);
    // A duplicate value: find and remove must take the first copy.
    add_row(CMD_APPEND, 6'd0,  32'h5A5A_5A5A, 0, 32'h0, 6'd0, ST_OK, 7'd0);
    add_row(CMD_FIND,   6'd0,  32'h5A5A_5A5A, 0, 32'h0, 6'd0, ST_OK, 7'd0);
    add_row(CMD_REMOVE, 6'd0,  32'h5A5A_5A5A, 0, 32'h0, 6'd0, ST_OK, 7'd0);
    add_row(CMD_POP,    6'd0,  32'h0,         0, 32'h0, 6'd0, ST_OK, 7'd0);
    add_row(CMD_POP,    6'd1,  32'h0,         0, 32'h0, 6'd0, ST_OK, 7'd0);
    add_row(CMD_POP,    6'd5,  32'h0,         1, 32'h0, 6'd0, ST_RANGE,     7'd1);
    add_row(CMD_REMOVE, 6'd0,  32'h1234_5678, 0, 32'h0, 6'd0, ST_OK, 7'd0);
    add_row(CMD_GET,    6'd0,  32'h0,         1, 32'h0, 6'd0, ST_RANGE,     7'd0);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      send_word(row.cmd, row.idx, row.val, row.typed, row.want);
    end
    wait_list_idle();

    // Random phases cycle through the fill, drain, search and balanced mixes;
    // fill phases append until the list reports full. The sender pauses for
    // the list to go quiet between phases, and the last phase never idles.
    for (int p = 0; p < PHASES; p++) begin
      mix = mix_t'(p % 4);
      if (p == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(pick_cmd(mix), pick_index(), pick_value(), 1'b0, none);
      end
      wait_list_idle();
    end

    // Leave a quiet margin after the last result before judging.
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("indexed_list_engine_tb: done, clean");
    end else begin
      $display("indexed_list_engine_tb: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest run with every search taking the whole
  // chain and every stall at its longest.
  initial begin
    #15_000_000;
    $display("indexed_list_engine_tb: done, errors");
    $finish;
  end

endmodule
